// ===== src/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned TmoW  = 8;
  localparam int unsigned DlyW  = 18;
  localparam int unsigned CfgDw = 16;

  // Command codes on the input channel.
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_WRITE    = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;
  localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

  // Operation kinds after classification.
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_WAIT  = 3'd5;
  localparam logic [2:0] OP_NOP   = 3'd6;

  // Bus sequencer phases.
  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_ST_A = 5'd1;
  localparam logic [4:0] PH_ST_B = 5'd2;
  localparam logic [4:0] PH_SP_A = 5'd3;
  localparam logic [4:0] PH_SP_B = 5'd4;
  localparam logic [4:0] PH_WR_A = 5'd5;
  localparam logic [4:0] PH_WR_B = 5'd6;
  localparam logic [4:0] PH_WR_C = 5'd7;
  localparam logic [4:0] PH_RD_A = 5'd8;
  localparam logic [4:0] PH_RD_B = 5'd9;
  localparam logic [4:0] PH_AK_A = 5'd10;
  localparam logic [4:0] PH_AK_B = 5'd11;
  localparam logic [4:0] PH_WA_A = 5'd12;
  localparam logic [4:0] PH_WA_B = 5'd13;
  localparam logic [4:0] PH_WA_P = 5'd14;

  // Configuration register indexes.
  localparam logic CFG_TICKS   = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam logic [TickW-1:0] TICKS_RST   = 16'd100;
  localparam logic [TmoW-1:0]  TIMEOUT_RST = 8'd250;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_sample;
  } op_t;

endpackage

// ===== src/i2cm_front.sv =====
`timescale 1ns / 1ps

module i2cm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  i2cm_pkg::in_item_t in_data,
  output logic               in_full,
  output logic               op_valid,
  output i2cm_pkg::op_t      op_data,
  input  logic               op_take
);

  i2cm_pkg::op_t op_cls;
  i2cm_pkg::op_t q_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          push_ok;
  logic          pop_ok;

  always_comb begin
    op_cls.tx_byte    = in_data.tx_byte;
    op_cls.send_ack   = in_data.send_ack;
    op_cls.sda_sample = in_data.sda_sample;
    case (in_data.command)
      i2cm_pkg::CMD_TICK:     op_cls.kind = i2cm_pkg::OP_TICK;
      i2cm_pkg::CMD_START:    op_cls.kind = i2cm_pkg::OP_START;
      i2cm_pkg::CMD_STOP:     op_cls.kind = i2cm_pkg::OP_STOP;
      i2cm_pkg::CMD_WRITE:    op_cls.kind = i2cm_pkg::OP_WRITE;
      i2cm_pkg::CMD_READ:     op_cls.kind = i2cm_pkg::OP_READ;
      i2cm_pkg::CMD_WAIT_ACK: op_cls.kind = i2cm_pkg::OP_WAIT;
      default:                op_cls.kind = i2cm_pkg::OP_NOP;
    endcase
  end

  assign in_full  = (cnt_r == 2'd2);
  assign op_valid = (cnt_r != 2'd0);
  assign op_data  = q_r[rd_ptr_r];
  assign push_ok  = in_push && !in_full;
  assign pop_ok   = op_take && op_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push_ok && pop_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= op_cls;
    end
  end

endmodule

// ===== src/i2cm_seq.sv =====
`timescale 1ns / 1ps

module i2cm_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [i2cm_pkg::CfgDw-1:0]    cfg_wdata,
  input  logic                          op_valid,
  input  i2cm_pkg::op_t                 op_data,
  output logic                          op_take,
  output logic                          res_push,
  output i2cm_pkg::out_item_t           res_data,
  input  logic                          res_full
);

  logic [i2cm_pkg::TickW-1:0] ticks_r;
  logic [i2cm_pkg::TmoW-1:0]  tmo_r;

  logic [4:0]                phase_r, phase_nxt;
  logic [3:0]                bit_r, bit_nxt;
  logic [7:0]                shift_r, shift_nxt;
  logic [i2cm_pkg::DlyW-1:0] dly_r, dly_nxt;
  logic [7:0]                poll_r, poll_nxt;
  logic                      scl_r, scl_nxt;
  logic                      sda_r, sda_nxt;
  logic                      ackc_r, ackc_nxt;
  logic                      tmo_flag_r, tmo_flag_nxt;
  logic [7:0]                rx_r, rx_nxt;

  logic                      fire;
  logic                      busy;
  logic                      done;
  logic                      rej;
  logic [i2cm_pkg::TickW-1:0] t_eff;
  logic [i2cm_pkg::DlyW-1:0] d1, d2, d4;
  logic [i2cm_pkg::DlyW-1:0] dec;
  logic [3:0]                bit_inc;
  logic                      do_poll;

  assign fire    = op_valid && !res_full;
  assign op_take = fire;
  assign busy    = (phase_r != i2cm_pkg::PH_IDLE);

  // A zero tick setting counts as one tick per delay unit.
  assign t_eff = (ticks_r == '0) ? {{(i2cm_pkg::TickW-1){1'b0}}, 1'b1} : ticks_r;
  assign d1    = {2'b00, t_eff};
  assign d2    = {1'b0, t_eff, 1'b0};
  assign d4    = {t_eff, 2'b00};
  assign dec   = (dly_r != '0) ? dly_r - {{(i2cm_pkg::DlyW-1){1'b0}}, 1'b1} : dly_r;
  assign bit_inc = bit_r + 4'd1;
  assign do_poll = (phase_r == i2cm_pkg::PH_WA_P)
                || ((phase_r == i2cm_pkg::PH_WA_B) && (dec == '0));

  always_comb begin
    phase_nxt    = phase_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    dly_nxt      = dly_r;
    poll_nxt     = poll_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    ackc_nxt     = ackc_r;
    tmo_flag_nxt = tmo_flag_r;
    rx_nxt       = rx_r;
    done         = 1'b0;
    rej          = 1'b0;

    case (op_data.kind)
      i2cm_pkg::OP_START, i2cm_pkg::OP_STOP, i2cm_pkg::OP_WRITE,
      i2cm_pkg::OP_READ, i2cm_pkg::OP_WAIT: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          tmo_flag_nxt = 1'b0;
          bit_nxt      = 4'd0;
          case (op_data.kind)
            i2cm_pkg::OP_START: begin
              sda_nxt   = 1'b1;
              scl_nxt   = 1'b1;
              phase_nxt = i2cm_pkg::PH_ST_A;
              dly_nxt   = d4;
            end
            i2cm_pkg::OP_STOP: begin
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
              phase_nxt = i2cm_pkg::PH_SP_A;
              dly_nxt   = d4;
            end
            i2cm_pkg::OP_WRITE: begin
              scl_nxt   = 1'b0;
              sda_nxt   = op_data.tx_byte[7];
              shift_nxt = {op_data.tx_byte[6:0], 1'b0};
              phase_nxt = i2cm_pkg::PH_WR_A;
              dly_nxt   = d2;
            end
            i2cm_pkg::OP_READ: begin
              sda_nxt   = 1'b1;
              shift_nxt = 8'd0;
              ackc_nxt  = op_data.send_ack;
              scl_nxt   = 1'b0;
              phase_nxt = i2cm_pkg::PH_RD_A;
              dly_nxt   = d2;
            end
            default: begin
              sda_nxt   = 1'b1;
              poll_nxt  = 8'd0;
              phase_nxt = i2cm_pkg::PH_WA_A;
              dly_nxt   = d1;
            end
          endcase
        end
      end
      i2cm_pkg::OP_TICK: begin
        if (busy) begin
          if (do_poll) begin
            if (!op_data.sda_sample) begin
              scl_nxt   = 1'b0;
              phase_nxt = i2cm_pkg::PH_IDLE;
              dly_nxt   = '0;
              done      = 1'b1;
            end else if (poll_r >= tmo_r) begin
              // Give up: pull both lines low and run a full stop.
              tmo_flag_nxt = 1'b1;
              scl_nxt      = 1'b0;
              sda_nxt      = 1'b0;
              phase_nxt    = i2cm_pkg::PH_SP_A;
              dly_nxt      = d4;
            end else begin
              poll_nxt  = poll_r + 8'd1;
              phase_nxt = i2cm_pkg::PH_WA_P;
              dly_nxt   = '0;
            end
          end else begin
            dly_nxt = dec;
            if (dec == '0) begin
              case (phase_r)
                i2cm_pkg::PH_ST_A: begin
                  sda_nxt   = 1'b0;
                  phase_nxt = i2cm_pkg::PH_ST_B;
                  dly_nxt   = d4;
                end
                i2cm_pkg::PH_ST_B: begin
                  scl_nxt   = 1'b0;
                  phase_nxt = i2cm_pkg::PH_IDLE;
                  done      = 1'b1;
                end
                i2cm_pkg::PH_SP_A: begin
                  scl_nxt   = 1'b1;
                  phase_nxt = i2cm_pkg::PH_SP_B;
                  dly_nxt   = d4;
                end
                i2cm_pkg::PH_SP_B: begin
                  sda_nxt   = 1'b1;
                  phase_nxt = i2cm_pkg::PH_IDLE;
                  done      = 1'b1;
                end
                i2cm_pkg::PH_WR_A: begin
                  scl_nxt   = 1'b1;
                  phase_nxt = i2cm_pkg::PH_WR_B;
                  dly_nxt   = d2;
                end
                i2cm_pkg::PH_WR_B: begin
                  scl_nxt   = 1'b0;
                  phase_nxt = i2cm_pkg::PH_WR_C;
                  dly_nxt   = d2;
                end
                i2cm_pkg::PH_WR_C: begin
                  bit_nxt = bit_inc;
                  if (bit_inc[3]) begin
                    phase_nxt = i2cm_pkg::PH_IDLE;
                    done      = 1'b1;
                  end else begin
                    sda_nxt   = shift_r[7];
                    shift_nxt = {shift_r[6:0], 1'b0};
                    phase_nxt = i2cm_pkg::PH_WR_A;
                    dly_nxt   = d2;
                  end
                end
                i2cm_pkg::PH_RD_A: begin
                  scl_nxt   = 1'b1;
                  shift_nxt = {shift_r[6:0], op_data.sda_sample};
                  phase_nxt = i2cm_pkg::PH_RD_B;
                  dly_nxt   = d1;
                end
                i2cm_pkg::PH_RD_B: begin
                  bit_nxt = bit_inc;
                  if (bit_inc[3]) begin
                    rx_nxt    = shift_r;
                    scl_nxt   = 1'b0;
                    sda_nxt   = ~ackc_r;
                    phase_nxt = i2cm_pkg::PH_AK_A;
                    dly_nxt   = d2;
                  end else begin
                    scl_nxt   = 1'b0;
                    phase_nxt = i2cm_pkg::PH_RD_A;
                    dly_nxt   = d2;
                  end
                end
                i2cm_pkg::PH_AK_A: begin
                  scl_nxt   = 1'b1;
                  phase_nxt = i2cm_pkg::PH_AK_B;
                  dly_nxt   = d2;
                end
                i2cm_pkg::PH_AK_B: begin
                  scl_nxt   = 1'b0;
                  phase_nxt = i2cm_pkg::PH_IDLE;
                  done      = 1'b1;
                end
                i2cm_pkg::PH_WA_A: begin
                  scl_nxt   = 1'b1;
                  phase_nxt = i2cm_pkg::PH_WA_B;
                  dly_nxt   = d1;
                end
                default: begin
                  phase_nxt = i2cm_pkg::PH_IDLE;
                  dly_nxt   = '0;
                  done      = 1'b1;
                end
              endcase
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_push              = fire;
    res_data.scl_level    = scl_nxt;
    res_data.sda_released = sda_nxt;
    res_data.busy_res     = (phase_nxt != i2cm_pkg::PH_IDLE);
    res_data.done_res     = done;
    res_data.rx_byte      = rx_nxt;
    res_data.ack_missing  = tmo_flag_nxt;
    res_data.rejected     = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r    <= i2cm_pkg::TICKS_RST;
      tmo_r      <= i2cm_pkg::TIMEOUT_RST;
      phase_r    <= i2cm_pkg::PH_IDLE;
      bit_r      <= 4'd0;
      shift_r    <= 8'd0;
      dly_r      <= '0;
      poll_r     <= 8'd0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      ackc_r     <= 1'b0;
      tmo_flag_r <= 1'b0;
      rx_r       <= 8'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == i2cm_pkg::CFG_TICKS) begin
          ticks_r <= cfg_wdata;
        end else begin
          tmo_r <= cfg_wdata[i2cm_pkg::TmoW-1:0];
        end
      end
      if (fire) begin
        phase_r    <= phase_nxt;
        bit_r      <= bit_nxt;
        shift_r    <= shift_nxt;
        dly_r      <= dly_nxt;
        poll_r     <= poll_nxt;
        scl_r      <= scl_nxt;
        sda_r      <= sda_nxt;
        ackc_r     <= ackc_nxt;
        tmo_flag_r <= tmo_flag_nxt;
        rx_r       <= rx_nxt;
      end
    end
  end

endmodule

// ===== src/i2cm_out_q.sv =====
`timescale 1ns / 1ps

module i2cm_out_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  i2cm_pkg::out_item_t res_data,
  output logic                res_full,
  output logic                out_empty,
  output i2cm_pkg::out_item_t out_data,
  input  logic                out_pop
);

  i2cm_pkg::out_item_t q_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          cnt_r;
  logic [1:0]          cnt_nxt;
  logic                push_ok;
  logic                pop_ok;

  assign res_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign out_data  = q_r[rd_ptr_r];
  assign push_ok   = res_push && !res_full;
  assign pop_ok    = out_pop && !out_empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push_ok && pop_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= res_data;
    end
  end

endmodule

// ===== src/i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps
// I2C master byte engine. Each item pushed on the input queue port is either a
// time tick or a bus command (start, stop, write byte, read byte, wait ack).
// Every accepted item produces exactly one result on the output queue port,
// carrying the SCL/SDA levels to drive plus busy, done, received byte,
// missing-ack and rejected status.
// Items pass a two-entry input queue, the bus sequencer (one item per cycle
// while the result queue has room) and a two-entry result queue. Each item is
// registered in the input queue and its result in the result queue before it
// can be popped, and with pop held high the block sustains one transfer per
// clock cycle in both directions; the sequencer's state update sets that rate.
// Configuration writes (tick scaling and ack timeout) take effect at once and
// are meant to be issued while no command is in progress.
// Reset puts the bus lines released high, the sequencer idle, the registers
// at their defaults and both queues empty. When the receiver stops popping,
// the result queue fills, the sequencer halts, and full rises once the input
// queue holds two items; nothing is lost.

module i2c_master_byte_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  i2cm_pkg::in_item_t         in_data,
  output logic                       in_full,
  output logic                       out_empty,
  output i2cm_pkg::out_item_t        out_data,
  input  logic                       out_pop,
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [i2cm_pkg::CfgDw-1:0] cfg_wdata
);

  logic                op_valid;
  i2cm_pkg::op_t       op_data;
  logic                op_take;
  logic                res_push;
  i2cm_pkg::out_item_t res_data;
  logic                res_full;

  i2cm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .op_valid (op_valid),
    .op_data  (op_data),
    .op_take  (op_take)
  );

  i2cm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .op_valid  (op_valid),
    .op_data   (op_data),
    .op_take   (op_take),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  i2cm_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full),
    .out_empty (out_empty),
    .out_data  (out_data),
    .out_pop   (out_pop)
  );

endmodule

// ===== src/i2cm_checker.sv =====
`timescale 1ns / 1ps

module i2cm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input i2cm_pkg::out_item_t out_data
);

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A finished command leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.done_res |-> !out_data.busy_res)
    else $error("done reported while still busy");

  // A command is only rejected while another one is running.
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.rejected |-> out_data.busy_res && !out_data.done_res)
    else $error("rejected command without a running command");

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed before transfer");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
